FILE: hdl/pcs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the period capture statistics core.
// No dependencies.
package pcs_pkg;

  localparam int COUNT_MAX_DEF    = 256;
  localparam int CAPTURE_BITS_DEF = 24;

  localparam int CLK_W   = 27;
  localparam int INT_W   = 16;
  localparam int TICK_W  = 32;
  localparam int FIELD_W = 24;
  localparam int FREQ_W  = 37;
  localparam int MILLI_W = 10;
  localparam int OP_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [MILLI_W-1:0] MILLI = 10'd1000;

  localparam logic [CLK_W-1:0] CLK_HZ_RST    = 27'd48000000;
  localparam logic [INT_W-1:0] HEARTBEAT_RST = 16'd50;
  localparam logic [INT_W-1:0] REPORT_RST    = 16'd100;

  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_CAPTURE = 2'd1;
  localparam logic [OP_W-1:0] OP_TOGGLE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PER,
    ST_PUL,
    ST_MUL_A,
    ST_MUL_B,
    ST_FRQ_GO,
    ST_FRQ
  } state_t;

  typedef enum logic [1:0] {
    DIV_PER,
    DIV_PUL,
    DIV_FRQ
  } div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     toggle;
    logic     tick;
    logic     div_start;
    div_sel_t div_sel;
    logic     store_per;
    logic     store_pul;
    logic     mul_a;
    logic     mul_b;
    logic     store_frq;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic report_due;
    logic count_zero;
    logic total_zero;
    logic div_done;
    logic out_blocked;
  } dp_sts_t;

endpackage

FILE: hdl/pcs_divider.sv
`timescale 1ns / 1ps
// Serial restoring divider, one quotient bit per cycle.
// Standalone; no package dependencies.
module pcs_divider #(
  parameter int NUM_W = 46,
  parameter int DEN_W = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy;
  logic [STEP_W-1:0] step;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   rem_shift;
  logic [DEN_W:0]   diff;

  always_comb begin
    rem_shift = {rem, quo[NUM_W-1]};
    diff      = rem_shift - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (!diff[DEN_W]) begin
        rem <= diff[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

FILE: hdl/pcs_datapath.sv
`timescale 1ns / 1ps
// Datapath: tick timers, running statistics, multipliers, result register.
// Depends on pcs_pkg and pcs_divider.
module pcs_datapath import pcs_pkg::*; #(
  parameter int COUNT_MAX    = COUNT_MAX_DEF,
  parameter int CAPTURE_BITS = CAPTURE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic [CLK_W-1:0]   clk_hz,
  input  logic [INT_W-1:0]   hb_int,
  input  logic [INT_W-1:0]   rp_int,
  input  logic [FIELD_W-1:0] period_count,
  input  logic [FIELD_W-1:0] pulse_count,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               led_on,
  output logic               report_valid,
  output logic [FIELD_W-1:0] avg_period,
  output logic [FIELD_W-1:0] avg_pulse,
  output logic [FIELD_W-1:0] min_period,
  output logic [FIELD_W-1:0] max_period,
  output logic [FREQ_W-1:0]  freq_millihz,
  output logic [TICK_W-1:0]  elapsed_ticks,
  output logic               count_saturated
);

  localparam int CAP_W   = (CAPTURE_BITS < FIELD_W) ? CAPTURE_BITS : FIELD_W;
  localparam int CNT_W   = $clog2(COUNT_MAX + 1);
  localparam int TOTAL_W = CAP_W + CNT_W;
  localparam int MA_W    = CLK_W + CNT_W;
  localparam int NUM_W   = MA_W + MILLI_W;

  logic [TICK_W-1:0]  tick_count;
  logic [TICK_W-1:0]  heartbeat_mark;
  logic [TICK_W-1:0]  report_mark;
  logic [TICK_W-1:0]  start_mark;
  logic               led_level;
  logic               collecting;
  logic               window_pending;
  logic               fresh_capture;
  logic [CNT_W-1:0]   sample_count;
  logic               overflowed;
  logic [TOTAL_W-1:0] period_total;
  logic [TOTAL_W-1:0] pulse_total;
  logic [CAP_W-1:0]   period_min;
  logic [CAP_W-1:0]   period_max;
  logic [MA_W-1:0]    mul_a;
  logic [NUM_W-1:0]   mul_b;

  logic [TICK_W-1:0]  tick_next;
  logic               hb_hit;
  logic               rp_hit;
  logic               report;
  logic [CAP_W-1:0]   per;
  logic [CAP_W-1:0]   pul;
  logic               drain;
  logic               clear_stats;

  logic               div_done;
  logic [NUM_W-1:0]   div_quo;
  logic [NUM_W-1:0]   div_num;
  logic [TOTAL_W-1:0] div_den;

  always_comb begin
    tick_next = tick_count + 1'b1;
    hb_hit    = (tick_next - heartbeat_mark) >= TICK_W'(hb_int);
    rp_hit    = (tick_next - report_mark) >= TICK_W'(rp_int);
    report    = (rp_hit || window_pending) && collecting && fresh_capture;
    per       = period_count[CAP_W-1:0];
    pul       = pulse_count[CAP_W-1:0];
    drain     = result_valid && !result_stall;
    clear_stats = (cmd.toggle && !collecting) ||
                  (cmd.tick && report && sample_count == '0) || cmd.finish;
  end

  always_comb begin
    sts.report_due  = report;
    sts.count_zero  = (sample_count == '0);
    sts.total_zero  = (period_total == '0);
    sts.div_done    = div_done;
    sts.out_blocked = result_valid && result_stall;
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_PER: begin
        div_num = NUM_W'(period_total);
        div_den = TOTAL_W'(sample_count);
      end
      DIV_PUL: begin
        div_num = NUM_W'(pulse_total);
        div_den = TOTAL_W'(sample_count);
      end
      DIV_FRQ: begin
        div_num = mul_b;
        div_den = period_total;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  pcs_divider #(
    .NUM_W (NUM_W),
    .DEN_W (TOTAL_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  // timers and collection state
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      heartbeat_mark <= '0;
      report_mark    <= '0;
      start_mark     <= '0;
      led_level      <= 1'b0;
      collecting     <= 1'b0;
      window_pending <= 1'b0;
      fresh_capture  <= 1'b0;
    end else if (cmd.tick) begin
      tick_count <= tick_next;
      if (hb_hit) begin
        heartbeat_mark <= tick_next;
        led_level      <= !led_level;
      end
      if (rp_hit) begin
        report_mark <= tick_next;
      end
      if (report) begin
        window_pending <= 1'b0;
        fresh_capture  <= 1'b0;
      end else if (rp_hit) begin
        window_pending <= 1'b1;
      end
    end else if (cmd.toggle) begin
      if (collecting) begin
        collecting <= 1'b0;
      end else begin
        collecting     <= 1'b1;
        window_pending <= 1'b0;
        report_mark    <= tick_count;
        start_mark     <= tick_count;
      end
    end else if (cmd.capture) begin
      if (window_pending) begin
        fresh_capture <= 1'b1;
      end
    end
  end

  // running statistics
  always_ff @(posedge clk) begin
    if (rst || clear_stats) begin
      sample_count <= '0;
      overflowed   <= 1'b0;
      period_total <= '0;
      pulse_total  <= '0;
      period_min   <= '1;
      period_max   <= '0;
    end else if (cmd.capture) begin
      if (per < period_min) begin
        period_min <= per;
      end
      if (per > period_max) begin
        period_max <= per;
      end
      if (sample_count != CNT_W'(COUNT_MAX)) begin
        period_total <= period_total + TOTAL_W'(per);
        pulse_total  <= pulse_total + TOTAL_W'(pul);
        sample_count <= sample_count + 1'b1;
      end else begin
        overflowed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_a) begin
      mul_a <= MA_W'(clk_hz) * MA_W'(sample_count);
    end
    if (cmd.mul_b) begin
      mul_b <= NUM_W'(mul_a) * NUM_W'(MILLI);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((cmd.tick && (!report || sample_count == '0)) || cmd.finish) begin
      result_valid <= 1'b1;
    end else if (drain) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      led_on          <= hb_hit ? !led_level : led_level;
      report_valid    <= report;
      avg_period      <= '0;
      avg_pulse       <= '0;
      freq_millihz    <= '0;
      min_period      <= report ? FIELD_W'(period_min) : '0;
      max_period      <= report ? FIELD_W'(period_max) : '0;
      elapsed_ticks   <= report ? tick_next - start_mark : '0;
      count_saturated <= report && overflowed;
    end
    if (cmd.store_per) begin
      avg_period <= FIELD_W'(div_quo);
    end
    if (cmd.store_pul) begin
      avg_pulse <= FIELD_W'(div_quo);
    end
    if (cmd.store_frq) begin
      freq_millihz <= FREQ_W'(div_quo);
    end
  end

endmodule

FILE: hdl/pcs_controller.sv
`timescale 1ns / 1ps
// Controller: accepts transactions and sequences the report computation.
// Depends on pcs_pkg.
module pcs_controller import pcs_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  logic [OP_W-1:0] operation,
  input  dp_sts_t         sts,
  output dp_cmd_t         cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    item_stall = (state != ST_IDLE) || (operation == OP_TICK && sts.out_blocked);
    accept     = item_valid && !item_stall;
    state_next = state;
    cmd        = '0;
    cmd.div_sel = DIV_PER;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (operation)
            OP_TICK: begin
              cmd.tick = 1'b1;
              if (sts.report_due && !sts.count_zero) begin
                cmd.div_start = 1'b1;
                state_next    = ST_PER;
              end
            end
            OP_CAPTURE: cmd.capture = 1'b1;
            OP_TOGGLE:  cmd.toggle  = 1'b1;
            default: ;
          endcase
        end
      end
      ST_PER: begin
        if (sts.div_done) begin
          cmd.store_per = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_PUL;
          state_next    = ST_PUL;
        end
      end
      ST_PUL: begin
        if (sts.div_done) begin
          cmd.store_pul = 1'b1;
          state_next    = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        cmd.mul_a  = 1'b1;
        state_next = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.mul_b  = 1'b1;
        state_next = ST_FRQ_GO;
      end
      ST_FRQ_GO: begin
        if (sts.total_zero) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_FRQ;
          state_next    = ST_FRQ;
        end
      end
      ST_FRQ: begin
        cmd.div_sel = DIV_FRQ;
        if (sts.div_done) begin
          cmd.store_frq = 1'b1;
          cmd.finish    = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: hdl/period_capture_statistics_core.sv
`timescale 1ns / 1ps
// Captures, start/stop and ticks without report: one transaction per cycle, but a tick
// stalls while result_stall holds a pending result; its result is presented the cycle
// after acceptance. Report tick: two or three passes of the NUM_W-bit serial divider,
// NUM_W = 27 + clog2(COUNT_MAX+1) + 10; input is stalled meanwhile.
// Synchronous reset clears all timers and statistics and restores register defaults.
module period_capture_statistics_core import pcs_pkg::*; #(
  parameter int COUNT_MAX    = COUNT_MAX_DEF,
  parameter int CAPTURE_BITS = CAPTURE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CLK_W-1:0]     cfg_data,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [OP_W-1:0]      operation,
  input  logic [FIELD_W-1:0]   period_count,
  input  logic [FIELD_W-1:0]   pulse_count,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 led_on,
  output logic                 report_valid,
  output logic [FIELD_W-1:0]   avg_period,
  output logic [FIELD_W-1:0]   avg_pulse,
  output logic [FIELD_W-1:0]   min_period,
  output logic [FIELD_W-1:0]   max_period,
  output logic [FREQ_W-1:0]    freq_millihz,
  output logic [TICK_W-1:0]    elapsed_ticks,
  output logic                 count_saturated
);

  logic [CLK_W-1:0] clk_hz;
  logic [INT_W-1:0] hb_int;
  logic [INT_W-1:0] rp_int;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      clk_hz <= CLK_HZ_RST;
      hb_int <= HEARTBEAT_RST;
      rp_int <= REPORT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CLOCK:     clk_hz <= cfg_data;
        CFG_HEARTBEAT: hb_int <= cfg_data[INT_W-1:0];
        CFG_REPORT:    rp_int <= cfg_data[INT_W-1:0];
        default: ;
      endcase
    end
  end

  pcs_controller u_controller (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .operation  (operation),
    .sts        (sts),
    .cmd        (cmd)
  );

  pcs_datapath #(
    .COUNT_MAX    (COUNT_MAX),
    .CAPTURE_BITS (CAPTURE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .clk_hz          (clk_hz),
    .hb_int          (hb_int),
    .rp_int          (rp_int),
    .period_count    (period_count),
    .pulse_count     (pulse_count),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .led_on          (led_on),
    .report_valid    (report_valid),
    .avg_period      (avg_period),
    .avg_pulse       (avg_pulse),
    .min_period      (min_period),
    .max_period      (max_period),
    .freq_millihz    (freq_millihz),
    .elapsed_ticks   (elapsed_ticks),
    .count_saturated (count_saturated)
  );

`ifndef NO_ASSERTIONS
  a_plain_tick_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !report_valid |->
      avg_period == '0 && avg_pulse == '0 && freq_millihz == '0 &&
      elapsed_ticks == '0 && !count_saturated)
    else $error("plain tick result carries report fields");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !result_valid)
    else $error("report finished into an occupied result register");

  a_div_held_off: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> item_stall)
    else $error("input accepted during report computation");
`endif

endmodule
